[hw/rtl/fcw_pkg.sv]
// Shared types and constants for the FAT12 cluster chain walker.
package fcw_pkg;

    localparam int PADDR_W = 3;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_ADVANCE = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam logic [1:0] STATUS_LOADED = 2'd0;
    localparam logic [1:0] STATUS_SECTOR = 2'd1;
    localparam logic [1:0] STATUS_END    = 2'd2;
    localparam logic [1:0] STATUS_BAD    = 2'd3;

    localparam logic [11:0] END_MARK          = 12'hFF8;
    localparam logic [11:0] FIRST_CLUSTER     = 12'd2;
    localparam logic [15:0] RESET_DATA_SECTOR = 16'd33;
    localparam logic [7:0]  NIB_MASK          = 8'h0F;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] group_index;
        logic [23:0] group_bytes;
        logic [11:0] start_cluster;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] cluster;
        logic [15:0] sector;
    } out_item_t;

    typedef struct packed {
        logic latch;
        logic mem_rd;
        logic commit;
    } fcw_cmd_t;

    typedef struct packed {
        logic [1:0] in_kind;
        logic       walk_active;
        logic       out_free;
    } fcw_stat_t;

endpackage

[hw/rtl/fcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fcw_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fcw_ctrl.sv]
// Controller state machine for the cluster chain walker.
module fcw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fcw_pkg::fcw_stat_t stat,
    output fcw_pkg::fcw_cmd_t  cmd
);
    import fcw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    priority if (stat.in_kind == KIND_UNUSED) begin
                        state_next = S_IDLE;
                    end else if (stat.in_kind == KIND_ADVANCE && stat.walk_active) begin
                        state_next = S_READ;
                    end else begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_READ: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign cmd.latch  = accept;
    assign cmd.mem_rd = (state_reg == S_READ);
    assign cmd.commit = (state_reg == S_EXEC) && stat.out_free;

endmodule

[hw/rtl/fcw_datapath.sv]
// Datapath: table banks, walk state and result register.
module fcw_datapath #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fcw_pkg::in_item_t  s_item,
    input  logic [15:0]        first_data_sector,
    input  fcw_pkg::fcw_cmd_t  cmd,
    output fcw_pkg::fcw_stat_t stat,
    input  logic               m_ready,
    output logic               m_valid,
    output fcw_pkg::out_item_t m_item
);
    import fcw_pkg::*;

    localparam int EVEN_DEPTH = (TABLE_ENTRIES + 1) / 2;
    localparam int ODD_DEPTH  = TABLE_ENTRIES / 2;
    localparam int EA_W       = $clog2(EVEN_DEPTH);
    localparam int OA_W       = $clog2(ODD_DEPTH);
    localparam logic [12:0] TABLE_LIMIT = 13'(TABLE_ENTRIES);

    in_item_t    item_reg;
    logic [11:0] cur_reg, cur_next;
    logic        walk_reg, walk_next;
    logic        m_valid_reg;
    out_item_t   m_item_reg, m_item_next;

    logic        we_even, we_odd;
    logic [11:0] wdata_even, wdata_odd;
    logic [11:0] rdata_even, rdata_odd;
    logic        cur_in_table;
    logic [11:0] entry;
    logic [7:0]  b0, b1, b2;
    logic [11:0] pick;

    assign b0 = item_reg.group_bytes[7:0];
    assign b1 = item_reg.group_bytes[15:8];
    assign b2 = item_reg.group_bytes[23:16];
    assign wdata_even = {4'(b1 & NIB_MASK), b0};
    assign wdata_odd  = {b2, b1[7:4]};

    assign we_even = cmd.commit && (item_reg.kind == KIND_LOAD)
                     && ({1'b0, item_reg.group_index, 1'b0} < TABLE_LIMIT);
    assign we_odd  = cmd.commit && (item_reg.kind == KIND_LOAD)
                     && ({1'b0, item_reg.group_index, 1'b1} < TABLE_LIMIT);

    fcw_ram #(.WIDTH(12), .DEPTH(EVEN_DEPTH)) u_even (
        .aclk  (aclk),
        .we    (we_even),
        .waddr (item_reg.group_index[EA_W-1:0]),
        .wdata (wdata_even),
        .re    (cmd.mem_rd),
        .raddr (cur_reg[EA_W:1]),
        .rdata (rdata_even)
    );

    fcw_ram #(.WIDTH(12), .DEPTH(ODD_DEPTH)) u_odd (
        .aclk  (aclk),
        .we    (we_odd),
        .waddr (item_reg.group_index[OA_W-1:0]),
        .wdata (wdata_odd),
        .re    (cmd.mem_rd),
        .raddr (cur_reg[OA_W:1]),
        .rdata (rdata_odd)
    );

    assign cur_in_table = ({1'b0, cur_reg} < TABLE_LIMIT);
    assign entry = cur_in_table ? (cur_reg[0] ? rdata_odd : rdata_even) : 12'd0;

    // cluster chosen for the sector sum
    assign pick = (item_reg.kind == KIND_START) ? item_reg.start_cluster : entry;

    always_comb begin
        cur_next           = cur_reg;
        walk_next          = walk_reg;
        m_item_next.status = STATUS_LOADED;
        m_item_next.sector = 16'd0;
        unique case (item_reg.kind)
            KIND_LOAD: begin
                m_item_next.status = STATUS_LOADED;
            end
            KIND_START: begin
                if (item_reg.start_cluster < FIRST_CLUSTER
                    || item_reg.start_cluster >= END_MARK) begin
                    walk_next          = 1'b0;
                    m_item_next.status = STATUS_BAD;
                end else begin
                    cur_next           = item_reg.start_cluster;
                    walk_next          = 1'b1;
                    m_item_next.status = STATUS_SECTOR;
                end
            end
            KIND_ADVANCE: begin
                if (!walk_reg) begin
                    m_item_next.status = STATUS_END;
                end else if (entry == 12'd0 || entry >= END_MARK) begin
                    walk_next          = 1'b0;
                    m_item_next.status = STATUS_END;
                end else begin
                    cur_next           = entry;
                    m_item_next.status = STATUS_SECTOR;
                end
            end
            default: begin
                m_item_next.status = STATUS_END;
            end
        endcase
        if (m_item_next.status == STATUS_SECTOR) begin
            m_item_next.sector = first_data_sector + {4'd0, pick} - {4'd0, FIRST_CLUSTER};
        end
        m_item_next.cluster = cur_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            item_reg <= s_item;
        end
        if (cmd.commit) begin
            m_item_reg <= m_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg     <= 12'd0;
            walk_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                cur_reg  <= cur_next;
                walk_reg <= walk_next;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.in_kind     = s_item.kind;
    assign stat.walk_active = walk_reg;
    assign stat.out_free    = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

[hw/rtl/fat12_cluster_chain_walker.sv]
// Top level of the FAT12 cluster chain walker.
//
// Input channel s_*: one transaction per item. kind LOAD writes a 3-byte
// table group (two 12-bit entries), START begins a walk at start_cluster,
// ADVANCE follows the table entry of the current cluster. Kind 3 is
// consumed and gives no result. Every other item gives one transaction on
// m_*: status, current cluster and its data sector (first_data_sector +
// cluster - 2, when status is sector valid).
// Timing: LOAD and START go from acceptance to S_EXEC, which registers
// the result; an ADVANCE during a walk first passes S_READ, for the
// registered read of the table banks. One item is in flight at a time.
// The result sits in an output register, so s_ready returns while the
// previous result still waits on m_ready; a stalled receiver holds the
// next result in execution until the register frees.
// Reset clears the walk state and the current cluster and sets
// first_data_sector to 33; the table contents are undefined until loaded.
// first_data_sector is written over the APB port at addresses 0 to 3.
module fat12_cluster_chain_walker #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  fcw_pkg::in_item_t            s_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output fcw_pkg::out_item_t           m_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import fcw_pkg::*;

    logic [15:0] fds_reg;
    logic        fds_sel;
    fcw_cmd_t    cmd;
    fcw_stat_t   stat;

    assign pready  = 1'b1;
    assign fds_sel = (paddr[PADDR_W-1] == 1'b0);
    assign prdata  = fds_sel ? {16'd0, fds_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fds_reg <= RESET_DATA_SECTOR;
        end else if (psel && penable && pwrite && pready && fds_sel) begin
            fds_reg <= pwdata[15:0];
        end
    end

    fcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fcw_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_item            (s_item),
        .first_data_sector (fds_reg),
        .cmd               (cmd),
        .stat              (stat),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_item            (m_item)
    );

endmodule

[hw/rtl/fcw_checker.sv]
// Port-level checks for the cluster chain walker, bound to the top level.
module fcw_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input fcw_pkg::in_item_t           s_item,
    input logic                        m_valid,
    input logic                        m_ready,
    input fcw_pkg::out_item_t          m_item,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [fcw_pkg::PADDR_W-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata,
    input logic                        pready
);
    import fcw_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result transaction changed while stalled");

    a_sector_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != STATUS_SECTOR |-> m_item.sector == 16'd0)
        else $error("sector nonzero without a valid sector");

    // an entry of one is followed, so cluster 1 can be reported
    a_cluster_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == STATUS_SECTOR
        |-> m_item.cluster != 12'd0 && m_item.cluster < END_MARK)
        else $error("reported cluster outside the chain range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.kind != KIND_UNUSED |=> !s_ready)
        else $error("second transaction accepted while one is in flight");

endmodule

bind fat12_cluster_chain_walker fcw_checker u_fcw_checker (.*);

[tb/sv/fcw_chain_checker.sv]
// Checker for the FAT12 cluster chain walker: predicts every result and compares it.
`timescale 1ns / 100ps
module fcw_chain_checker
    import fcw_pkg::*;
#(
    parameter int                 TABLE_ENTRIES    = 4096,
    parameter logic [PADDR_W-1:0] SECTOR_BASE_ADDR = '0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  in_item_t           s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  out_item_t          m_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output int                 err_count,
    output int                 pending,
    output int                 checked
);

    logic [11:0] fat_copy [TABLE_ENTRIES];
    logic [11:0] walk_cluster;
    bit          walk_on;
    logic [15:0] sector_base;
    out_item_t   due_results[$];
    out_item_t   next_due;
    out_item_t   want;
    bit          has_result;
    int          errs = 0;
    int          seen = 0;

    function automatic logic [15:0] sector_at(input logic [11:0] c);
        return sector_base + {4'd0, c} - {4'd0, FIRST_CLUSTER};
    endfunction

    task automatic step_walk(input in_item_t it, output bit yields, output out_item_t res);
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [12:0] lo_idx;
        logic [11:0] nxt;
        yields = 1'b1;
        res    = '0;
        b0     = it.group_bytes[7:0];
        b1     = it.group_bytes[15:8];
        b2     = it.group_bytes[23:16];
        case (it.kind)
            KIND_LOAD: begin
                lo_idx = {it.group_index, 1'b0};
                if (lo_idx < TABLE_ENTRIES)
                    fat_copy[lo_idx] = (12'(b1 & NIB_MASK) << 8) | 12'(b0);
                if (lo_idx + 1 < TABLE_ENTRIES)
                    fat_copy[lo_idx + 1] = (12'(b2) << 4) | 12'(b1 >> 4);
                res.status = STATUS_LOADED;
            end
            KIND_START: begin
                if (it.start_cluster < FIRST_CLUSTER || it.start_cluster >= END_MARK) begin
                    walk_on    = 1'b0;
                    res.status = STATUS_BAD;
                end else begin
                    walk_cluster = it.start_cluster;
                    walk_on      = 1'b1;
                    res.status   = STATUS_SECTOR;
                    res.sector   = sector_at(walk_cluster);
                end
            end
            KIND_ADVANCE: begin
                if (!walk_on) begin
                    res.status = STATUS_END;
                end else begin
                    nxt = (walk_cluster < TABLE_ENTRIES) ? fat_copy[walk_cluster] : 12'd0;
                    if (nxt == 12'd0 || nxt >= END_MARK) begin
                        walk_on    = 1'b0;
                        res.status = STATUS_END;
                    end else begin
                        walk_cluster = nxt;
                        res.status   = STATUS_SECTOR;
                        res.sector   = sector_at(walk_cluster);
                    end
                end
            end
            default: yields = 1'b0;
        endcase
        res.cluster = walk_cluster;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            walk_on      = 1'b0;
            walk_cluster = '0;
            sector_base  = RESET_DATA_SECTOR;
            due_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen++;
                if (due_results.size() == 0) begin
                    errs++;
                    $error("result transaction with none expected: status %0d cluster %0d sector %0d",
                           m_item.status, m_item.cluster, m_item.sector);
                end else begin
                    want = due_results.pop_front();
                    if (m_item.status !== want.status) begin
                        errs++;
                        $error("status: expected %0d, got %0d", want.status, m_item.status);
                    end
                    if (m_item.cluster !== want.cluster) begin
                        errs++;
                        $error("cluster: expected %0d, got %0d", want.cluster, m_item.cluster);
                    end
                    if (m_item.sector !== want.sector) begin
                        errs++;
                        $error("sector: expected %0d, got %0d", want.sector, m_item.sector);
                    end
                end
            end
            if (s_valid && s_ready) begin
                step_walk(s_item, has_result, next_due);
                if (has_result)
                    due_results.push_back(next_due);
            end
            if (psel && penable && pwrite && pready && paddr == SECTOR_BASE_ADDR)
                sector_base = pwdata[15:0];
        end
        err_count <= errs;
        pending   <= due_results.size();
        checked   <= seen;
    end

endmodule

[tb/sv/tb_fat12_cluster_chain_walker.sv]
// Testbench top for the FAT12 cluster chain walker: stimulus, sector base phases, verdict.
`timescale 1ns / 100ps
module tb_fat12_cluster_chain_walker;
    import fcw_pkg::*;

    localparam int TABLE_ENTRIES         = 4096;
    localparam int REG_FIRST_DATA_SECTOR = 0;
    localparam logic [PADDR_W-1:0] SECTOR_BASE_ADDR = PADDR_W'(4 * REG_FIRST_DATA_SECTOR);
    localparam int ITEMS_PER_PHASE       = 270;
    localparam int PHASES                = 6;
    localparam int SETTLE_CYCLES         = 6;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_item_t           s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_item_t          m_item;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    int err_count;
    int pending;
    int checked;

    bit quiet     = 1'b0;
    int gap_pct   = 20;
    int stall_pct = 8;
    int n_load    = 0;
    int n_start   = 0;
    int n_adv     = 0;
    int n_unused  = 0;

    // stimulus-side view of the table, so no walk reads an entry never loaded
    logic [11:0] shadow_fat [TABLE_ENTRIES];
    bit          shadow_set [TABLE_ENTRIES];
    logic [11:0] walk_at = '0;
    bit          walking = 1'b0;

    always #2 aclk = ~aclk;

    fat12_cluster_chain_walker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fcw_chain_checker #(
        .TABLE_ENTRIES    (TABLE_ENTRIES),
        .SECTOR_BASE_ADDR (SECTOR_BASE_ADDR)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .err_count (err_count),
        .pending   (pending),
        .checked   (checked)
    );

    function automatic in_item_t random_fields();
        in_item_t it;
        it.kind          = 2'($urandom_range(0, 3));
        it.group_index   = 11'($urandom_range(0, 2047));
        it.group_bytes   = 24'($urandom_range(0, 24'hFFFFFF));
        it.start_cluster = 12'($urandom_range(0, 4095));
        return it;
    endfunction

    function automatic logic [11:0] random_entry();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 12'd0;
        if (r < 16)
            return 12'($urandom_range(END_MARK, 12'hFFF));
        if (r < 22)
            return 12'd1;
        if (r < 85)
            return 12'($urandom_range(2, 63));
        return 12'($urandom_range(FIRST_CLUSTER, END_MARK - 12'd1));
    endfunction

    task automatic idle(input int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic send(input in_item_t it);
        logic [11:0] nxt;
        if (!quiet && $urandom_range(0, 99) < gap_pct)
            idle($urandom_range(1, 13));
        @(negedge aclk);
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        case (it.kind)
            KIND_LOAD: begin
                shadow_fat[{it.group_index, 1'b0}] = it.group_bytes[11:0];
                shadow_fat[{it.group_index, 1'b1}] = it.group_bytes[23:12];
                shadow_set[{it.group_index, 1'b0}] = 1'b1;
                shadow_set[{it.group_index, 1'b1}] = 1'b1;
                n_load++;
            end
            KIND_START: begin
                walking = it.start_cluster >= FIRST_CLUSTER && it.start_cluster < END_MARK;
                if (walking)
                    walk_at = it.start_cluster;
                n_start++;
            end
            KIND_ADVANCE: begin
                if (walking) begin
                    nxt = shadow_fat[walk_at];
                    if (nxt == 12'd0 || nxt >= END_MARK)
                        walking = 1'b0;
                    else
                        walk_at = nxt;
                end
                n_adv++;
            end
            default: n_unused++;
        endcase
    endtask

    // two entries pack as {odd, even} in the 3-byte group
    task automatic load_group(input logic [10:0] g, input logic [11:0] lo, input logic [11:0] hi);
        in_item_t it;
        it             = random_fields();
        it.kind        = KIND_LOAD;
        it.group_index = g;
        it.group_bytes = {hi, lo};
        send(it);
    endtask

    task automatic start_walk(input logic [11:0] c);
        in_item_t it;
        it               = random_fields();
        it.kind          = KIND_START;
        it.start_cluster = c;
        send(it);
    endtask

    task automatic advance();
        in_item_t it;
        it      = random_fields();
        it.kind = KIND_ADVANCE;
        send(it);
    endtask

    task automatic unused_item();
        in_item_t it;
        it      = random_fields();
        it.kind = KIND_UNUSED;
        send(it);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_sector_base(input logic [15:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SECTOR_BASE_ADDR;
        pwdata  <= {16'd0, v};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_step();
        int       r;
        in_item_t it;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            unused_item();
        end else if (r < 10) begin
            if ($urandom_range(0, 1))
                start_walk(12'($urandom_range(0, 1)));
            else
                start_walk(12'($urandom_range(END_MARK, 12'hFFF)));
        end else if (walking && !shadow_set[walk_at]) begin
            load_group(walk_at[11:1], random_entry(), random_entry());
        end else if (walking || r < 15) begin
            advance();
        end else if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 4) == 0)
                start_walk(12'($urandom_range(FIRST_CLUSTER, END_MARK - 12'd1)));
            else
                start_walk(12'($urandom_range(FIRST_CLUSTER, 63)));
        end else if ($urandom_range(0, 9) == 0) begin
            it      = random_fields();
            it.kind = KIND_LOAD;
            send(it);
        end else if ($urandom_range(0, 4) == 0) begin
            load_group(11'($urandom_range(0, 2047)), random_entry(), random_entry());
        end else begin
            load_group(11'($urandom_range(0, 31)), random_entry(), random_entry());
        end
    endtask

    initial begin : rx_stalls
        int n;
        forever begin
            if (quiet || $urandom_range(0, 99) >= stall_pct) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                n = $urandom_range(1, 13);
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] base;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            quiet   = (ph == PHASES - 1);
            gap_pct = (ph == 2) ? 0 : $urandom_range(5, 35);
            if (ph > 0) begin
                case (ph)
                    1: base = 16'd0;
                    2: base = 16'd61440;
                    4: base = 16'd1;
                    default: base = 16'($urandom_range(0, 61440));
                endcase
                drain();
                write_sector_base(base);
            end
            if (ph == 0) begin
                load_group(11'h7FF, 12'hFFF, 12'hFFF);
                load_group(11'd3, 12'h000, 12'h000);
                load_group(11'd0, 12'hABC, 12'hFF8);
                load_group(11'd1, 12'h003, 12'h001);
                load_group(11'd2, 12'h000, 12'hFFF);
                load_group(11'h7FF, 12'hFF7, 12'h005);
                load_group(11'd2043, 12'h123, 12'hFF8);
                advance();                  // no walk yet
                start_walk(12'd0);
                start_walk(12'd1);
                start_walk(12'hFF8);
                start_walk(12'hFFF);
                start_walk(12'd2);
                advance();                  // 2 -> 3
                advance();                  // 3 -> 1, entry of one
                advance();                  // 1 ends on FF8
                advance();
                start_walk(12'd4);
                advance();                  // zero entry ends
                start_walk(12'd4094);
                advance();                  // -> FF7
                advance();
                start_walk(12'hFF7);
                start_walk(12'd0);          // bad start drops the walk
                advance();
                unused_item();
                start_walk(12'd5);
                advance();
            end
            if (ph == 1) begin
                // base 0: cluster 1 wraps the sector to FFFF
                load_group(11'd0, 12'hABC, 12'hFF8);
                load_group(11'd1, 12'h003, 12'h001);
                start_walk(12'd2);
                advance();
                advance();
                advance();
            end
            while (n_load + n_start + n_adv < (ph + 1) * ITEMS_PER_PHASE)
                random_step();
        end
        drain();
        $display("Covered %0d loads, %0d walk starts, %0d advances, %0d unused-kind items over %0d sector bases.",
                 n_load, n_start, n_adv, n_unused, PHASES);
        $display("Compared %0d result transactions, %0d mismatches.", checked, err_count);
        if (err_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
